// ===== hdl/ppi_pkg.sv =====
package ppi_pkg;

  // field and datapath widths
  localparam int COEF_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int DET_W     = 4 * COEF_W;
  localparam int NUM_W     = 3 * COEF_W;
  localparam int TERM_W    = 4 * COEF_W;
  localparam int VMAG_W    = TERM_W + 1;
  localparam int QUO_W     = COEF_W + 1;
  localparam int SPLIT     = QUO_W - FRAC_W;
  localparam int THR_SHIFT = 4 * FRAC_W - 32;

  // threshold after reset, about 1e-6 in units of 2^-32
  localparam logic [31:0] THR_RESET = 32'd4295;

  // clamp magnitudes for the positive and the negative side
  localparam logic [COEF_W-1:0] MAG_POS = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] MAG_NEG = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] first_normal_x;
    logic signed [COEF_W-1:0] first_normal_y;
    logic signed [COEF_W-1:0] first_normal_z;
    logic signed [COEF_W-1:0] first_offset;
    logic signed [COEF_W-1:0] second_normal_x;
    logic signed [COEF_W-1:0] second_normal_y;
    logic signed [COEF_W-1:0] second_normal_z;
    logic signed [COEF_W-1:0] second_offset;
  } ppi_in_t;

  typedef struct packed {
    logic                     valid_res;
    logic signed [COEF_W-1:0] start_x;
    logic signed [COEF_W-1:0] start_y;
    logic signed [COEF_W-1:0] start_z;
    logic signed [COEF_W-1:0] dir_x;
    logic signed [COEF_W-1:0] dir_y;
    logic signed [COEF_W-1:0] dir_z;
    logic                     saturated;
  } ppi_out_t;

  // normal magnitudes and signs, kept for the start point
  typedef struct packed {
    logic [2:0][COEF_W-1:0] am;
    logic [2:0][COEF_W-1:0] bm;
    logic [2:0]             asg;
    logic [2:0]             bsg;
  } ppi_src_t;

  // per item data that rides along to the end
  typedef struct packed {
    logic [DET_W-1:0]       det;
    logic                   par;
    logic [2:0][COEF_W-1:0] dir;
    logic                   dsat;
  } ppi_side_t;

  typedef struct packed {
    ppi_side_t        side;
    logic [NUM_W-1:0] nm0;
    logic             ns0;
    logic [NUM_W-1:0] nm1;
    logic             ns1;
    ppi_src_t         src;
  } ppi_gram_t;

  typedef struct packed {
    ppi_side_t              side;
    logic [2:0][VMAG_W-1:0] vm;
    logic [2:0]             vs;
  } ppi_comb_t;

  typedef struct packed {
    ppi_side_t              side;
    logic [2:0]             vs;
    logic [2:0]             ovf;
    logic [2:0][VMAG_W-1:0] r;
    logic [2:0][QUO_W-1:0]  lo;
    logic [2:0][QUO_W-1:0]  q;
  } ppi_div_t;

  function automatic logic signed [PROD_W-1:0] mul_s32(logic signed [COEF_W-1:0] x,
                                                       logic signed [COEF_W-1:0] y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

  function automatic logic [PROD_W-1:0] mul_u32(logic [COEF_W-1:0] x,
                                                logic [COEF_W-1:0] y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

  function automatic logic [COEF_W-1:0] abs32(logic signed [COEF_W-1:0] x);
    return x[COEF_W-1] ? COEF_W'(-x) : COEF_W'(x);
  endfunction

  // sign and magnitude to clamped two's complement, flag on top
  function automatic logic [COEF_W:0] sat_out(logic neg, logic big, logic [COEF_W-1:0] mag);
    logic [COEF_W-1:0] lim;
    logic              over;
    logic [COEF_W-1:0] m;
    lim  = neg ? MAG_NEG : MAG_POS;
    over = big || (mag > lim);
    m    = over ? lim : mag;
    return {over, (neg ? COEF_W'(-m) : m)};
  endfunction

endpackage

// ===== hdl/ppi_gram.sv =====
module ppi_gram (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  ppi_pkg::ppi_in_t   in_data,
  input  logic [31:0]        thr,
  output logic               out_vld,
  output ppi_pkg::ppi_gram_t out_data
);
  import ppi_pkg::*;

  typedef struct packed {
    logic [COEF_W-1:0] d1m;
    logic [COEF_W-1:0] d2m;
    logic              d1s;
    logic              d2s;
  } off_t;

  logic signed [COEF_W-1:0] a [3];
  logic signed [COEF_W-1:0] b [3];

  // stage 1
  logic                     v1;
  logic signed [PROD_W-1:0] aa [3];
  logic signed [PROD_W-1:0] bb [3];
  logic signed [PROD_W-1:0] ab [3];
  logic signed [PROD_W-1:0] cp [3];
  logic signed [PROD_W-1:0] cn [3];
  ppi_src_t                 src1;
  off_t                     off1;
  // stage 2
  logic                     v2;
  logic [PROD_W-1:0]        n00_2, n11_2;
  logic signed [PROD_W+1:0] n01_2;
  logic signed [PROD_W:0]   cr2 [3];
  ppi_src_t                 src2;
  off_t                     off2;
  // stage 3
  logic                     v3;
  logic [PROD_W-1:0]        n00_3, n11_3, m01_3;
  logic                     s01_3;
  logic [2:0][COEF_W-1:0]   dir3;
  logic                     dsat3;
  ppi_src_t                 src3;
  off_t                     off3;
  logic [PROD_W-1:0]        crm [3];
  logic [COEF_W:0]          dsr [3];
  // stage 4
  logic                     v4;
  logic [PROD_W-1:0]        pll, plh, phl, phh, qll, qlh, qhh;
  logic [PROD_W-1:0]        tal, tah, tbl, tbh, tcl, tch, tdl, tdh;
  logic                     sa4, sb4, sc4, sd4;
  logic [2:0][COEF_W-1:0]   dir4;
  logic                     dsat4;
  ppi_src_t                 src4;
  // stage 5
  logic                     v5;
  logic [DET_W-1:0]         p5, q5;
  logic [NUM_W-1:0]         ta5, tb5, tc5, td5;
  logic                     sa5, sb5, sc5, sd5;
  logic [2:0][COEF_W-1:0]   dir5;
  logic                     dsat5;
  ppi_src_t                 src5;
  // stage 6
  logic                     v6;
  logic [DET_W:0]           det6;
  logic signed [NUM_W+1:0]  num0_6, num1_6;
  logic [2:0][COEF_W-1:0]   dir6;
  logic                     dsat6;
  ppi_src_t                 src6;

  function automatic logic signed [NUM_W+1:0] sgn_num(logic n, logic [NUM_W-1:0] m);
    return n ? -$signed((NUM_W+2)'(m)) : $signed((NUM_W+2)'(m));
  endfunction

  // unpack the two planes
  always_comb begin
    a[0] = $signed(in_data.first_normal_x);
    a[1] = $signed(in_data.first_normal_y);
    a[2] = $signed(in_data.first_normal_z);
    b[0] = $signed(in_data.second_normal_x);
    b[1] = $signed(in_data.second_normal_y);
    b[2] = $signed(in_data.second_normal_z);
  end

  // dir magnitude down by the fraction bits, then clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crm[i] = cr2[i][PROD_W] ? PROD_W'(-cr2[i]) : cr2[i][PROD_W-1:0];
      dsr[i] = sat_out(cr2[i][PROD_W], |crm[i][PROD_W-1:PROD_W-FRAC_W],
                       crm[i][PROD_W-FRAC_W-1:FRAC_W]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_vld <= v6;
    end
  end

  // stage 1: element products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        aa[i] <= mul_s32(a[i], a[i]);
        bb[i] <= mul_s32(b[i], b[i]);
        ab[i] <= mul_s32(a[i], b[i]);
        src1.am[i]  <= abs32(a[i]);
        src1.bm[i]  <= abs32(b[i]);
        src1.asg[i] <= a[i][COEF_W-1];
        src1.bsg[i] <= b[i][COEF_W-1];
      end
      cp[0] <= mul_s32(a[1], b[2]);
      cn[0] <= mul_s32(a[2], b[1]);
      cp[1] <= mul_s32(a[2], b[0]);
      cn[1] <= mul_s32(a[0], b[2]);
      cp[2] <= mul_s32(a[0], b[1]);
      cn[2] <= mul_s32(a[1], b[0]);
      off1.d1m <= abs32($signed(in_data.first_offset));
      off1.d2m <= abs32($signed(in_data.second_offset));
      off1.d1s <= in_data.first_offset[COEF_W-1];
      off1.d2s <= in_data.second_offset[COEF_W-1];
    end
  end

  // stage 2: gram sums and cross differences
  always_ff @(posedge clk) begin
    if (en) begin
      n00_2 <= $unsigned(aa[0]) + $unsigned(aa[1]) + $unsigned(aa[2]);
      n11_2 <= $unsigned(bb[0]) + $unsigned(bb[1]) + $unsigned(bb[2]);
      n01_2 <= (PROD_W+2)'(ab[0]) + (PROD_W+2)'(ab[1]) + (PROD_W+2)'(ab[2]);
      for (int i = 0; i < 3; i++) begin
        cr2[i] <= (PROD_W+1)'(cp[i]) - (PROD_W+1)'(cn[i]);
      end
      src2 <= src1;
      off2 <= off1;
    end
  end

  // stage 3: dot product magnitude, direction done
  always_ff @(posedge clk) begin
    if (en) begin
      n00_3 <= n00_2;
      n11_3 <= n11_2;
      m01_3 <= n01_2[PROD_W+1] ? PROD_W'(-n01_2) : n01_2[PROD_W-1:0];
      s01_3 <= n01_2[PROD_W+1];
      for (int i = 0; i < 3; i++) begin
        dir3[i] <= dsr[i][COEF_W-1:0];
      end
      dsat3 <= dsr[0][COEF_W] | dsr[1][COEF_W] | dsr[2][COEF_W];
      src3 <= src2;
      off3 <= off2;
    end
  end

  // stage 4: 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pll <= mul_u32(n00_3[COEF_W-1:0], n11_3[COEF_W-1:0]);
      plh <= mul_u32(n00_3[COEF_W-1:0], n11_3[PROD_W-1:COEF_W]);
      phl <= mul_u32(n00_3[PROD_W-1:COEF_W], n11_3[COEF_W-1:0]);
      phh <= mul_u32(n00_3[PROD_W-1:COEF_W], n11_3[PROD_W-1:COEF_W]);
      qll <= mul_u32(m01_3[COEF_W-1:0], m01_3[COEF_W-1:0]);
      qlh <= mul_u32(m01_3[COEF_W-1:0], m01_3[PROD_W-1:COEF_W]);
      qhh <= mul_u32(m01_3[PROD_W-1:COEF_W], m01_3[PROD_W-1:COEF_W]);
      tal <= mul_u32(m01_3[COEF_W-1:0], off3.d2m);
      tah <= mul_u32(m01_3[PROD_W-1:COEF_W], off3.d2m);
      tbl <= mul_u32(n11_3[COEF_W-1:0], off3.d1m);
      tbh <= mul_u32(n11_3[PROD_W-1:COEF_W], off3.d1m);
      tcl <= mul_u32(m01_3[COEF_W-1:0], off3.d1m);
      tch <= mul_u32(m01_3[PROD_W-1:COEF_W], off3.d1m);
      tdl <= mul_u32(n00_3[COEF_W-1:0], off3.d2m);
      tdh <= mul_u32(n00_3[PROD_W-1:COEF_W], off3.d2m);
      sa4 <= s01_3 ^ off3.d2s;
      sb4 <= off3.d1s;
      sc4 <= s01_3 ^ off3.d1s;
      sd4 <= off3.d2s;
      dir4  <= dir3;
      dsat4 <= dsat3;
      src4  <= src3;
    end
  end

  // stage 5: partial product sums
  always_ff @(posedge clk) begin
    if (en) begin
      p5 <= DET_W'(pll) + (DET_W'(plh) << COEF_W) + (DET_W'(phl) << COEF_W)
          + (DET_W'(phh) << PROD_W);
      q5 <= DET_W'(qll) + (DET_W'(qlh) << (COEF_W + 1)) + (DET_W'(qhh) << PROD_W);
      ta5 <= NUM_W'(tal) + (NUM_W'(tah) << COEF_W);
      tb5 <= NUM_W'(tbl) + (NUM_W'(tbh) << COEF_W);
      tc5 <= NUM_W'(tcl) + (NUM_W'(tch) << COEF_W);
      td5 <= NUM_W'(tdl) + (NUM_W'(tdh) << COEF_W);
      sa5 <= sa4;
      sb5 <= sb4;
      sc5 <= sc4;
      sd5 <= sd4;
      dir5  <= dir4;
      dsat5 <= dsat4;
      src5  <= src4;
    end
  end

  // stage 6: determinant and the two numerators
  always_ff @(posedge clk) begin
    if (en) begin
      det6   <= {1'b0, p5} - {1'b0, q5};
      num0_6 <= sgn_num(sa5, ta5) - sgn_num(sb5, tb5);
      num1_6 <= sgn_num(sc5, tc5) - sgn_num(sd5, td5);
      dir6  <= dir5;
      dsat6 <= dsat5;
      src6  <= src5;
    end
  end

  // stage 7: parallel test, numerator magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.side.det  <= det6[DET_W-1:0];
      out_data.side.par  <= det6[DET_W] || (det6 == '0)
                            || (det6[DET_W-1:0] < (DET_W'(thr) << THR_SHIFT));
      out_data.side.dir  <= dir6;
      out_data.side.dsat <= dsat6;
      out_data.nm0 <= num0_6[NUM_W+1] ? NUM_W'(-num0_6) : num0_6[NUM_W-1:0];
      out_data.ns0 <= num0_6[NUM_W+1];
      out_data.nm1 <= num1_6[NUM_W+1] ? NUM_W'(-num1_6) : num1_6[NUM_W-1:0];
      out_data.ns1 <= num1_6[NUM_W+1];
      out_data.src <= src6;
    end
  end

endmodule

// ===== hdl/ppi_comb.sv =====
module ppi_comb (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  ppi_pkg::ppi_gram_t in_data,
  output logic               out_vld,
  output ppi_pkg::ppi_comb_t out_data
);
  import ppi_pkg::*;

  // stage 8
  logic              v8;
  logic [PROD_W-1:0] pa [3][3];
  logic [PROD_W-1:0] pb [3][3];
  logic [2:0]        ts0_8, ts1_8;
  ppi_side_t         side8;
  // stage 9
  logic              v9;
  logic [TERM_W-1:0] t0_9 [3];
  logic [TERM_W-1:0] t1_9 [3];
  logic [2:0]        ts0_9, ts1_9;
  ppi_side_t         side9;
  // stage 10
  logic                    v10;
  logic signed [VMAG_W:0]  vsum [3];
  ppi_side_t               side10;

  function automatic logic signed [VMAG_W:0] sgn_term(logic n, logic [TERM_W-1:0] m);
    return n ? -$signed((VMAG_W+1)'(m)) : $signed((VMAG_W+1)'(m));
  endfunction

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v8 <= in_vld;
      v9 <= v8;
      v10 <= v9;
      out_vld <= v10;
    end
  end

  // stage 8: numerator chunks times normal components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          pa[i][c] <= mul_u32(in_data.nm0[c*COEF_W +: COEF_W], in_data.src.am[i]);
          pb[i][c] <= mul_u32(in_data.nm1[c*COEF_W +: COEF_W], in_data.src.bm[i]);
        end
        ts0_8[i] <= in_data.ns0 ^ in_data.src.asg[i];
        ts1_8[i] <= in_data.ns1 ^ in_data.src.bsg[i];
      end
      side8 <= in_data.side;
    end
  end

  // stage 9: chunk sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t0_9[i] <= TERM_W'(pa[i][0]) + (TERM_W'(pa[i][1]) << COEF_W)
                 + (TERM_W'(pa[i][2]) << PROD_W);
        t1_9[i] <= TERM_W'(pb[i][0]) + (TERM_W'(pb[i][1]) << COEF_W)
                 + (TERM_W'(pb[i][2]) << PROD_W);
      end
      ts0_9 <= ts0_8;
      ts1_9 <= ts1_8;
      side9 <= side8;
    end
  end

  // stage 10: signed sum of both terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vsum[i] <= sgn_term(ts0_9[i], t0_9[i]) + sgn_term(ts1_9[i], t1_9[i]);
      end
      side10 <= side9;
    end
  end

  // stage 11: magnitude and sign for the divider
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_data.vm[i] <= vsum[i][VMAG_W] ? VMAG_W'(-vsum[i]) : vsum[i][VMAG_W-1:0];
        out_data.vs[i] <= vsum[i][VMAG_W];
      end
      out_data.side <= side10;
    end
  end

endmodule

// ===== hdl/ppi_div.sv =====
module ppi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  ppi_pkg::ppi_comb_t in_data,
  output logic              out_vld,
  output ppi_pkg::ppi_div_t out_data
);
  import ppi_pkg::*;

  logic     vld [QUO_W+1];
  ppi_div_t st  [QUO_W+1];
  ppi_div_t nx  [QUO_W];
  ppi_div_t s0;

  // entry: overflow check on the upper dividend bits, seed remainder
  always_comb begin
    s0 = '0;
    s0.side = in_data.side;
    s0.vs   = in_data.vs;
    for (int i = 0; i < 3; i++) begin
      s0.ovf[i] = DET_W'(in_data.vm[i][VMAG_W-1:SPLIT]) >= in_data.side.det;
      s0.r[i]   = VMAG_W'(in_data.vm[i][VMAG_W-1:SPLIT]);
      s0.lo[i]  = {in_data.vm[i][SPLIT-1:0], FRAC_W'(0)};
    end
  end

  // one restoring step per stage, three lanes
  always_comb begin
    logic [VMAG_W-1:0] rs;
    logic              ge;
    for (int k = 0; k < QUO_W; k++) begin
      nx[k] = st[k];
      for (int i = 0; i < 3; i++) begin
        rs = {st[k].r[i][DET_W-1:0], st[k].lo[i][QUO_W-1]};
        ge = rs >= {1'b0, st[k].side.det};
        nx[k].r[i]  = ge ? rs - {1'b0, st[k].side.det} : rs;
        nx[k].lo[i] = {st[k].lo[i][QUO_W-2:0], 1'b0};
        nx[k].q[i]  = {st[k].q[i][QUO_W-2:0], ge};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_vld;
      for (int k = 0; k < QUO_W; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= s0;
      for (int k = 0; k < QUO_W; k++) begin
        st[k+1] <= nx[k];
      end
    end
  end

  assign out_vld  = vld[QUO_W];
  assign out_data = st[QUO_W];

endmodule

// ===== hdl/plane_plane_intersection_line.sv =====
// channel  | signals                      | direction
// ---------+------------------------------+----------
// input    | in_valid, in_ready, in_data  | in
// output   | out_valid, out_ready, out_data | out
// config   | cfg_wen, cfg_wdata           | in
//
// one plane pair per cycle while the skid entry is empty; 46 register stages: 7
// gram/determinant stages, 4 numerator stages, a 34-stage divider (entry stage
// plus one quotient bit per stage) and the output register
// rst (synchronous) empties the pipeline and loads det_threshold with 4295
// a two-entry output register/skid buffer lets one more item finish while a
// result waits; the whole pipeline holds only when the skid entry is full
module plane_plane_intersection_line (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppi_pkg::ppi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppi_pkg::ppi_out_t out_data,
  input  logic              cfg_wen,
  input  logic [31:0]       cfg_wdata
);
  import ppi_pkg::*;

  logic               thr;
  logic [31:0]        det_threshold;
  logic               en;
  logic               g_vld, c_vld, d_vld;
  ppi_gram_t          g_data;
  ppi_comb_t          c_data;
  ppi_div_t           d_data;
  logic [COEF_W:0]    sres [3];
  ppi_out_t           res;
  ppi_out_t           skid;
  logic               skid_valid;
  logic               push, pop;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THR_RESET;
    end else if (cfg_wen) begin
      det_threshold <= cfg_wdata;
    end
  end

  assign thr      = skid_valid;
  assign en       = !thr;
  assign in_ready = en;

  ppi_gram u_gram (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid), .in_data(in_data),
    .thr(det_threshold), .out_vld(g_vld), .out_data(g_data)
  );

  ppi_comb u_comb (
    .clk(clk), .rst(rst), .en(en), .in_vld(g_vld), .in_data(g_data),
    .out_vld(c_vld), .out_data(c_data)
  );

  ppi_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(c_vld), .in_data(c_data),
    .out_vld(d_vld), .out_data(d_data)
  );

  // clamp quotients and assemble the result
  always_comb begin
    res = '0;
    for (int i = 0; i < 3; i++) begin
      sres[i] = sat_out(d_data.vs[i], d_data.ovf[i] | d_data.q[i][QUO_W-1],
                        d_data.q[i][COEF_W-1:0]);
    end
    if (!d_data.side.par) begin
      res.valid_res = 1'b1;
      res.start_x   = $signed(sres[0][COEF_W-1:0]);
      res.start_y   = $signed(sres[1][COEF_W-1:0]);
      res.start_z   = $signed(sres[2][COEF_W-1:0]);
      res.dir_x     = $signed(d_data.side.dir[0]);
      res.dir_y     = $signed(d_data.side.dir[1]);
      res.dir_z     = $signed(d_data.side.dir[2]);
      res.saturated = d_data.side.dsat | sres[0][COEF_W] | sres[1][COEF_W]
                    | sres[2][COEF_W];
    end
  end

  assign push = en && d_vld;
  assign pop  = out_valid && out_ready;

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without a stalled output");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |-> out_data.start_x == 0 && out_data.start_y == 0
      && out_data.dir_x == 0 && out_data.dir_z == 0 && !out_data.saturated)
    else $error("parallel result carries nonzero payload");

  a_sat_needs_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.valid_res)
    else $error("saturation flagged on a parallel result");
`endif

endmodule
